### rtl/core/pms_pkg.sv
package pms_pkg;

   // fixed design constants
   localparam int SLEEP_PERIODS   = 10000;
   localparam int FULL_DUTY       = 1000;
   localparam int IDLE_DUTY_LEVEL = 300;
   localparam int RAMP_UP_STEP    = 1;
   localparam int RAMP_DOWN_STEP  = 1;
   localparam int PWM_PERIOD      = 1000;
   localparam int DUTY_SCALE      = 1000;

   // field widths
   localparam int SAMPLE_W   = 12;
   localparam int GAIN_W     = 16;
   localparam int ACC_W      = 28;
   localparam int FRAC_W     = 16;
   localparam int CNT_W      = 17;
   localparam int DUTY_W     = 10;
   localparam int PWM_W      = 16;
   localparam int STATE_W    = 2;
   localparam int TIMEOUT_W  = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // duty to compare value: floor(duty * PWM_PERIOD / DUTY_SCALE) by reciprocal
   localparam int      PWM_FRAC_BITS = 20;
   localparam longint  PWM_MULT      =
      (longint'(PWM_PERIOD) * (longint'(1) << PWM_FRAC_BITS) + longint'(DUTY_SCALE) - 1)
      / longint'(DUTY_SCALE);
   localparam int      PWM_MULT_W    = 27;
   localparam int      PWM_PROD_W    = DUTY_W + PWM_MULT_W;

   // motor states
   localparam logic [STATE_W-1:0] ST_IDLE  = 2'd0;
   localparam logic [STATE_W-1:0] ST_SLEEP = 2'd1;
   localparam logic [STATE_W-1:0] ST_WORK  = 2'd2;
   localparam logic [STATE_W-1:0] ST_ERROR = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_CURRENT_OFFSET    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FILTER_GAIN       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OVERCURRENT_LEVEL = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_UNDERLOAD_LEVEL   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_STAY_WORK_LEVEL   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_START_WORK_LEVEL  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_OVERTEMP_LEVEL    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_IDLE_TIMEOUT      = 3'd7;

   typedef struct packed {
      logic [SAMPLE_W-1:0]  overcurrent_level;
      logic [SAMPLE_W-1:0]  underload_level;
      logic [SAMPLE_W-1:0]  stay_work_level;
      logic [SAMPLE_W-1:0]  start_work_level;
      logic [SAMPLE_W-1:0]  overtemp_level;
      logic [TIMEOUT_W-1:0] idle_timeout;
   } cfg_type;

   typedef struct packed {
      logic work_seen;
      logic over_current;
      logic under_load;
      logic over_temp;
      logic oil_over_temp;
   } flags_type;

endpackage

### rtl/core/pump_motor_supervisor.sv
// pump motor supervisor: filters, threshold flags, state machine and duty ramp
// a taken request passes the update reg, then the output reg, on its way to rsp_valid
// throughput: one request per cycle unless rsp_stall backs up; the state update is combinational
// logic with a single 29x17 filter multiply per channel, the compare value one more stage
// reset (synchronous, active high): filters and counter zero, state WORK, duty zero,
// registers to their defaults, all pipeline stages empty
module pump_motor_supervisor (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [pms_pkg::SAMPLE_W-1:0]  req_pressure_a,
   input  logic [pms_pkg::SAMPLE_W-1:0]  req_pressure_b,
   input  logic [pms_pkg::SAMPLE_W-1:0]  req_temperature,
   input  logic [pms_pkg::SAMPLE_W-1:0]  req_current_raw,
   input  logic                          req_oil_temp_ok,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pms_pkg::STATE_W-1:0]   rsp_motor_state,
   output logic [pms_pkg::DUTY_W-1:0]    rsp_duty_permille,
   output logic [pms_pkg::PWM_W-1:0]     rsp_pwm_compare,
   output logic [pms_pkg::SAMPLE_W-1:0]  rsp_current_value,
   output logic                          rsp_work_seen,
   output logic                          rsp_over_current,
   output logic                          rsp_under_load,
   output logic                          rsp_over_temp,
   output logic                          rsp_oil_over_temp,
   // register write port
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [pms_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pms_pkg::CSR_DATA_W-1:0] csr_data
);
   import pms_pkg::*;

   // configuration registers
   logic [SAMPLE_W-1:0] current_offset_ff;
   logic [GAIN_W-1:0]   filter_gain_ff;
   cfg_type             cfg_ff;

   // input stage
   logic                in_vld_ff;
   logic [SAMPLE_W-1:0] pa_ff, pb_ff, temp_ff, craw_ff;
   logic                oil_ok_ff;

   // update stage
   logic                mid_vld_ff;
   logic [SAMPLE_W-1:0] mid_current_ff;
   flags_type           mid_flags_ff;

   // output stage
   logic                rsp_vld_ff;
   flags_type           rsp_flags;

   // stage flow control
   logic                req_take, mid_load, out_load;

   logic [SAMPLE_W-1:0] cur_sample;
   logic [SAMPLE_W-1:0] filt_a, filt_b, filt_cur;
   flags_type           flags;
   logic [STATE_W-1:0]  ctrl_mode;
   logic [DUTY_W-1:0]   ctrl_duty;

   // each stage moves when the one after it is empty or emptying
   assign out_load  = mid_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign mid_load  = in_vld_ff && (!mid_vld_ff || out_load);
   assign req_stall = in_vld_ff && !mid_load;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_vld_ff;

   // writes must only happen while idle; the block does not enforce it and the port never waits
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         current_offset_ff        <= '0;
         filter_gain_ff           <= GAIN_W'(25736);
         cfg_ff.overcurrent_level <= SAMPLE_W'(1094);
         cfg_ff.underload_level   <= SAMPLE_W'(1094);
         cfg_ff.stay_work_level   <= SAMPLE_W'(200);
         cfg_ff.start_work_level  <= SAMPLE_W'(300);
         cfg_ff.overtemp_level    <= SAMPLE_W'(3008);
         cfg_ff.idle_timeout      <= TIMEOUT_W'(5000);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_CURRENT_OFFSET:    current_offset_ff        <= csr_data[SAMPLE_W-1:0];
            REG_FILTER_GAIN:       filter_gain_ff           <= csr_data[GAIN_W-1:0];
            REG_OVERCURRENT_LEVEL: cfg_ff.overcurrent_level <= csr_data[SAMPLE_W-1:0];
            REG_UNDERLOAD_LEVEL:   cfg_ff.underload_level   <= csr_data[SAMPLE_W-1:0];
            REG_STAY_WORK_LEVEL:   cfg_ff.stay_work_level   <= csr_data[SAMPLE_W-1:0];
            REG_START_WORK_LEVEL:  cfg_ff.start_work_level  <= csr_data[SAMPLE_W-1:0];
            REG_OVERTEMP_LEVEL:    cfg_ff.overtemp_level    <= csr_data[SAMPLE_W-1:0];
            REG_IDLE_TIMEOUT:      cfg_ff.idle_timeout      <= csr_data[TIMEOUT_W-1:0];
         endcase
      end
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         mid_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (req_take) begin
            in_vld_ff <= 1'b1;
         end else if (mid_load) begin
            in_vld_ff <= 1'b0;
         end
         if (mid_load) begin
            mid_vld_ff <= 1'b1;
         end else if (out_load) begin
            mid_vld_ff <= 1'b0;
         end
         if (out_load) begin
            rsp_vld_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // request payload capture
   always_ff @(posedge clock) begin
      if (req_take) begin
         pa_ff     <= req_pressure_a;
         pb_ff     <= req_pressure_b;
         temp_ff   <= req_temperature;
         craw_ff   <= req_current_raw;
         oil_ok_ff <= req_oil_temp_ok;
      end
   end

   // offset removal, clamped at zero
   assign cur_sample = (craw_ff > current_offset_ff) ? craw_ff - current_offset_ff : '0;

   pms_filter u_filt_a (
      .clock  (clock),
      .reset  (reset),
      .en     (mid_load),
      .sample (pa_ff),
      .gain   (filter_gain_ff),
      .value  (filt_a)
   );

   pms_filter u_filt_b (
      .clock  (clock),
      .reset  (reset),
      .en     (mid_load),
      .sample (pb_ff),
      .gain   (filter_gain_ff),
      .value  (filt_b)
   );

   pms_filter u_filt_cur (
      .clock  (clock),
      .reset  (reset),
      .en     (mid_load),
      .sample (cur_sample),
      .gain   (filter_gain_ff),
      .value  (filt_cur)
   );

   // state machine, counter and duty; its state registers are the update stage payload
   pms_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .en          (mid_load),
      .cfg         (cfg_ff),
      .filt_a      (filt_a),
      .filt_b      (filt_b),
      .filt_cur    (filt_cur),
      .temperature (temp_ff),
      .oil_temp_ok (oil_ok_ff),
      .flags       (flags),
      .mode        (ctrl_mode),
      .duty        (ctrl_duty)
   );

   always_ff @(posedge clock) begin
      if (mid_load) begin
         mid_current_ff <= filt_cur;
         mid_flags_ff   <= flags;
      end
   end

   // output register with the compare value computed on the way in
   pms_pwm u_pwm (
      .clock       (clock),
      .load        (out_load),
      .mode        (ctrl_mode),
      .duty        (ctrl_duty),
      .cur         (mid_current_ff),
      .flags       (mid_flags_ff),
      .mode_out    (rsp_motor_state),
      .duty_out    (rsp_duty_permille),
      .compare_out (rsp_pwm_compare),
      .cur_out     (rsp_current_value),
      .flags_out   (rsp_flags)
   );

   assign rsp_work_seen     = rsp_flags.work_seen;
   assign rsp_over_current  = rsp_flags.over_current;
   assign rsp_under_load    = rsp_flags.under_load;
   assign rsp_over_temp     = rsp_flags.over_temp;
   assign rsp_oil_over_temp = rsp_flags.oil_over_temp;

   // error state is entered exactly on over temperature and left on the next clean period
   a_error_tracks_temp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_motor_state == ST_ERROR) == rsp_over_temp))
      else $error("motor state disagrees with over temperature flag");

   // the ramp never goes past full duty
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_duty_permille <= DUTY_W'(FULL_DUTY)))
      else $error("duty above full scale");

   // a pending update stage result is held until the output stage takes it
   a_mid_hold: assert property (@(posedge clock) disable iff (reset)
      (mid_vld_ff && !out_load) |=> (mid_vld_ff && $stable(mid_current_ff)
                                     && $stable(ctrl_duty) && $stable(ctrl_mode)))
      else $error("update stage result lost while output stalled");

endmodule

### rtl/core/pms_filter.sv
module pms_filter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic [pms_pkg::SAMPLE_W-1:0]  sample,
   input  logic [pms_pkg::GAIN_W-1:0]    gain,
   output logic [pms_pkg::SAMPLE_W-1:0]  value
);
   import pms_pkg::*;

   localparam int DIFF_W = ACC_W + 1;
   localparam int PROD_W = DIFF_W + GAIN_W + 1;
   localparam int SUM_W  = PROD_W - FRAC_W;

   logic        [ACC_W-1:0]  acc_ff;
   logic        [ACC_W-1:0]  acc_in;
   logic signed [DIFF_W-1:0] diff;
   logic signed [PROD_W-1:0] prod;
   logic signed [SUM_W-1:0]  delta;
   logic        [SUM_W-1:0]  sum;

   // y' = y + floor((x*2^16 - y) * g / 2^16)
   always_comb begin
      diff   = $signed({1'b0, sample, {FRAC_W{1'b0}}}) - $signed({1'b0, acc_ff});
      prod   = diff * $signed({1'b0, gain});
      delta  = prod[PROD_W-1:FRAC_W];
      sum    = {{(SUM_W-ACC_W){1'b0}}, acc_ff} + $unsigned(delta);
      acc_in = sum[ACC_W-1:0];
   end

   assign value = acc_in[ACC_W-1:FRAC_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (en) begin
         acc_ff <= acc_in;
      end
   end

endmodule

### rtl/core/pms_ctrl.sv
module pms_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  pms_pkg::cfg_type              cfg,
   input  logic [pms_pkg::SAMPLE_W-1:0]  filt_a,
   input  logic [pms_pkg::SAMPLE_W-1:0]  filt_b,
   input  logic [pms_pkg::SAMPLE_W-1:0]  filt_cur,
   input  logic [pms_pkg::SAMPLE_W-1:0]  temperature,
   input  logic                          oil_temp_ok,
   output pms_pkg::flags_type            flags,
   output logic [pms_pkg::STATE_W-1:0]   mode,
   output logic [pms_pkg::DUTY_W-1:0]    duty
);
   import pms_pkg::*;

   logic [STATE_W-1:0] mode_ff, mode_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [DUTY_W-1:0]  duty_ff, duty_in;

   logic [SAMPLE_W-1:0] level;
   logic [CNT_W-1:0]    cnt_inc;
   logic [CNT_W-1:0]    idle_limit;
   logic [DUTY_W-1:0]   target;
   logic [DUTY_W:0]     duty_up;
   logic [DUTY_W-1:0]   duty_down;

   // work threshold follows the state held before this update
   always_comb begin
      level = (mode_ff == ST_WORK) ? cfg.stay_work_level : cfg.start_work_level;
      flags.work_seen     = (filt_a >= level) || (filt_b >= level);
      flags.over_current  = filt_cur >= cfg.overcurrent_level;
      flags.under_load    = filt_cur >= cfg.underload_level;
      flags.over_temp     = temperature >= cfg.overtemp_level;
      flags.oil_over_temp = !oil_temp_ok;
   end

   always_comb begin
      cnt_inc    = (cnt_ff != '1) ? cnt_ff + CNT_W'(1) : cnt_ff;
      idle_limit = {1'b0, cfg.idle_timeout} + CNT_W'(1);
      mode_in    = mode_ff;
      cnt_in     = cnt_ff;
      if (flags.over_temp) begin
         mode_in = ST_ERROR;
         cnt_in  = '0;
      end else begin
         unique case (mode_ff)
            ST_WORK: begin
               if (flags.work_seen || flags.under_load) begin
                  cnt_in = '0;
               end else if (cnt_inc > idle_limit) begin
                  mode_in = ST_SLEEP;
                  cnt_in  = '0;
               end else begin
                  cnt_in = cnt_inc;
               end
            end
            ST_SLEEP: begin
               if (cnt_inc >= CNT_W'(SLEEP_PERIODS)) begin
                  mode_in = ST_IDLE;
                  cnt_in  = '0;
               end else begin
                  cnt_in = cnt_inc;
               end
            end
            ST_IDLE: begin
               if (flags.work_seen) begin
                  mode_in = ST_WORK;
                  cnt_in  = '0;
               end
            end
            ST_ERROR: begin
               mode_in = ST_WORK;
               cnt_in  = '0;
            end
         endcase
      end
   end

   // duty ramp toward the target of the new state, never overshooting
   always_comb begin
      case (mode_in)
         ST_WORK:  target = DUTY_W'(FULL_DUTY);
         ST_ERROR: target = '0;
         default:  target = DUTY_W'(IDLE_DUTY_LEVEL);
      endcase
      duty_up   = {1'b0, duty_ff} + (DUTY_W+1)'(RAMP_UP_STEP);
      duty_down = (duty_ff > DUTY_W'(RAMP_DOWN_STEP)) ?
                  duty_ff - DUTY_W'(RAMP_DOWN_STEP) : '0;
      if (duty_ff < target) begin
         duty_in = (duty_up > {1'b0, target}) ? target : duty_up[DUTY_W-1:0];
      end else if (duty_ff > target) begin
         duty_in = (duty_down < target) ? target : duty_down;
      end else begin
         duty_in = duty_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ST_WORK;
         cnt_ff  <= '0;
         duty_ff <= '0;
      end else if (en) begin
         mode_ff <= mode_in;
         cnt_ff  <= cnt_in;
         duty_ff <= duty_in;
      end
   end

   assign mode = mode_ff;
   assign duty = duty_ff;

endmodule

### rtl/core/pms_pwm.sv
module pms_pwm (
   input  logic                          clock,
   input  logic                          load,
   input  logic [pms_pkg::STATE_W-1:0]   mode,
   input  logic [pms_pkg::DUTY_W-1:0]    duty,
   input  logic [pms_pkg::SAMPLE_W-1:0]  cur,
   input  pms_pkg::flags_type            flags,
   output logic [pms_pkg::STATE_W-1:0]   mode_out,
   output logic [pms_pkg::DUTY_W-1:0]    duty_out,
   output logic [pms_pkg::PWM_W-1:0]     compare_out,
   output logic [pms_pkg::SAMPLE_W-1:0]  cur_out,
   output pms_pkg::flags_type            flags_out
);
   import pms_pkg::*;

   logic [STATE_W-1:0]    mode_ff;
   logic [DUTY_W-1:0]     duty_ff;
   logic [PWM_W-1:0]      compare_ff, compare_in;
   logic [SAMPLE_W-1:0]   cur_ff;
   flags_type             flags_ff;
   logic [PWM_PROD_W-1:0] prod;

   // constant reciprocal multiply replaces the divide by the duty scale
   always_comb begin
      prod       = {{PWM_MULT_W{1'b0}}, duty} * PWM_PROD_W'(PWM_MULT);
      compare_in = prod[PWM_FRAC_BITS +: PWM_W];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         mode_ff    <= mode;
         duty_ff    <= duty;
         compare_ff <= compare_in;
         cur_ff     <= cur;
         flags_ff   <= flags;
      end
   end

   assign mode_out    = mode_ff;
   assign duty_out    = duty_ff;
   assign compare_out = compare_ff;
   assign cur_out     = cur_ff;
   assign flags_out   = flags_ff;

endmodule

### verif/pms_tb_pkg.sv
package pms_tb_pkg;

   import pms_pkg::*;

   // one control period of adc samples
   typedef struct packed {
      logic [SAMPLE_W-1:0] pressure_a;
      logic [SAMPLE_W-1:0] pressure_b;
      logic [SAMPLE_W-1:0] temperature;
      logic [SAMPLE_W-1:0] current_raw;
      logic                oil_temp_ok;
   } adc_set_type;

   // supervisor status reported for one period
   typedef struct packed {
      logic [STATE_W-1:0]  motor_state;
      logic [DUTY_W-1:0]   duty_permille;
      logic [PWM_W-1:0]    pwm_compare;
      logic [SAMPLE_W-1:0] current_value;
      flags_type           flags;
   } motor_status_type;

   class motor_status_tracker;

      // register copies
      logic [SAMPLE_W-1:0]  offset_reg;
      logic [GAIN_W-1:0]    gain_reg;
      logic [SAMPLE_W-1:0]  over_cur_lvl;
      logic [SAMPLE_W-1:0]  under_lvl;
      logic [SAMPLE_W-1:0]  stay_lvl;
      logic [SAMPLE_W-1:0]  start_lvl;
      logic [SAMPLE_W-1:0]  temp_lvl;
      logic [TIMEOUT_W-1:0] timeout_reg;

      // supervisor state
      logic [ACC_W-1:0]     filt_pa;
      logic [ACC_W-1:0]     filt_pb;
      logic [ACC_W-1:0]     filt_cur;
      logic [STATE_W-1:0]   mode_q;
      logic [CNT_W-1:0]     quiet_cnt;
      logic [DUTY_W-1:0]    duty_q;

      motor_status_type status_due[$];
      int errors;

      function new();
         offset_reg   = '0;
         gain_reg     = 16'd25736;
         over_cur_lvl = 12'd1094;
         under_lvl    = 12'd1094;
         stay_lvl     = 12'd200;
         start_lvl    = 12'd300;
         temp_lvl     = 12'd3008;
         timeout_reg  = 16'd5000;
         filt_pa      = '0;
         filt_pb      = '0;
         filt_cur     = '0;
         mode_q       = ST_WORK;
         quiet_cnt    = '0;
         duty_q       = '0;
         errors       = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            REG_CURRENT_OFFSET:    offset_reg   = val[SAMPLE_W-1:0];
            REG_FILTER_GAIN:       gain_reg     = val[GAIN_W-1:0];
            REG_OVERCURRENT_LEVEL: over_cur_lvl = val[SAMPLE_W-1:0];
            REG_UNDERLOAD_LEVEL:   under_lvl    = val[SAMPLE_W-1:0];
            REG_STAY_WORK_LEVEL:   stay_lvl     = val[SAMPLE_W-1:0];
            REG_START_WORK_LEVEL:  start_lvl    = val[SAMPLE_W-1:0];
            REG_OVERTEMP_LEVEL:    temp_lvl     = val[SAMPLE_W-1:0];
            REG_IDLE_TIMEOUT:      timeout_reg  = val[TIMEOUT_W-1:0];
            default: ;
         endcase
      endfunction

      // first-order low pass, arithmetic shift gives the floor of the step
      function logic [ACC_W-1:0] lowpass(logic [ACC_W-1:0] acc, logic [SAMPLE_W-1:0] x);
         longint diff;
         longint prod;
         longint sum;
         diff = longint'({x, 16'h0000}) - longint'(acc);
         prod = diff * longint'(gain_reg);
         sum  = longint'(acc) + (prod >>> FRAC_W);
         return sum[ACC_W-1:0];
      endfunction

      function void take_samples(adc_set_type s);
         logic [SAMPLE_W-1:0] cur;
         logic [SAMPLE_W-1:0] fa;
         logic [SAMPLE_W-1:0] fb;
         logic [SAMPLE_W-1:0] fc;
         logic [SAMPLE_W-1:0] level;
         logic [STATE_W-1:0]  next_mode;
         bit work, oc, ul, ot;
         int target;
         int duty;
         motor_status_type st;

         cur      = (s.current_raw > offset_reg) ? s.current_raw - offset_reg : '0;
         filt_pa  = lowpass(filt_pa, s.pressure_a);
         filt_pb  = lowpass(filt_pb, s.pressure_b);
         filt_cur = lowpass(filt_cur, cur);
         fa = filt_pa[ACC_W-1:FRAC_W];
         fb = filt_pb[ACC_W-1:FRAC_W];
         fc = filt_cur[ACC_W-1:FRAC_W];

         level = (mode_q == ST_WORK) ? stay_lvl : start_lvl;
         work  = (fa >= level) || (fb >= level);
         oc    = fc >= over_cur_lvl;
         ul    = fc >= under_lvl;
         ot    = s.temperature >= temp_lvl;

         next_mode = mode_q;
         if (ot) begin
            next_mode = ST_ERROR;
            quiet_cnt = '0;
         end else begin
            case (mode_q)
               ST_WORK: begin
                  if (work || ul) begin
                     quiet_cnt = '0;
                  end else begin
                     if (quiet_cnt != {CNT_W{1'b1}}) quiet_cnt = quiet_cnt + 1'b1;
                     if (int'(quiet_cnt) > int'(timeout_reg) + 1) next_mode = ST_SLEEP;
                  end
               end
               ST_SLEEP: begin
                  if (quiet_cnt != {CNT_W{1'b1}}) quiet_cnt = quiet_cnt + 1'b1;
                  if (int'(quiet_cnt) >= SLEEP_PERIODS) next_mode = ST_IDLE;
               end
               ST_IDLE: begin
                  if (work) next_mode = ST_WORK;
               end
               default: next_mode = ST_WORK;
            endcase
         end
         if (next_mode != mode_q) quiet_cnt = '0;
         mode_q = next_mode;

         case (mode_q)
            ST_WORK:  target = FULL_DUTY;
            ST_ERROR: target = 0;
            default:  target = IDLE_DUTY_LEVEL;
         endcase
         duty = int'(duty_q);
         if (duty < target) begin
            duty = duty + RAMP_UP_STEP;
            if (duty > target) duty = target;
         end else if (duty > target) begin
            duty = (duty > RAMP_DOWN_STEP) ? duty - RAMP_DOWN_STEP : 0;
            if (duty < target) duty = target;
         end
         duty_q = duty[DUTY_W-1:0];

         st.motor_state         = mode_q;
         st.duty_permille       = duty_q;
         st.pwm_compare         = PWM_W'(PWM_PERIOD * int'(duty_q) / DUTY_SCALE);
         st.current_value       = fc;
         st.flags.work_seen     = work;
         st.flags.over_current  = oc;
         st.flags.under_load    = ul;
         st.flags.over_temp     = ot;
         st.flags.oil_over_temp = !s.oil_temp_ok;
         status_due.push_back(st);
      endfunction

      function void check_field(string what, logic [15:0] want, logic [15:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         end
      endfunction

      function void compare_status(motor_status_type got);
         motor_status_type want;
         if (status_due.size() == 0) begin
            errors++;
            $display("%0t: status with nothing pending, expected none, actual state %0d duty %0d",
                     $time, got.motor_state, got.duty_permille);
         end else begin
            want = status_due.pop_front();
            check_field("motor_state", 16'(want.motor_state), 16'(got.motor_state));
            check_field("duty_permille", 16'(want.duty_permille), 16'(got.duty_permille));
            check_field("pwm_compare", want.pwm_compare, got.pwm_compare);
            check_field("current_value", 16'(want.current_value), 16'(got.current_value));
            check_field("work_seen", 16'(want.flags.work_seen), 16'(got.flags.work_seen));
            check_field("over_current", 16'(want.flags.over_current),
                        16'(got.flags.over_current));
            check_field("under_load", 16'(want.flags.under_load), 16'(got.flags.under_load));
            check_field("over_temp", 16'(want.flags.over_temp), 16'(got.flags.over_temp));
            check_field("oil_over_temp", 16'(want.flags.oil_over_temp),
                        16'(got.flags.oil_over_temp));
         end
      endfunction

      function int pending();
         return status_due.size();
      endfunction

      function void count_leftover();
         if (status_due.size() != 0) begin
            errors += status_due.size();
            $display("%0t: status never returned, expected %0d more, actual 0",
                     $time, status_due.size());
         end
      endfunction

   endclass

endpackage

### verif/tb_top.sv
module tb_top;

   import pms_pkg::*;
   import pms_tb_pkg::*;

   localparam int SETTLE_CYCLES  = 8;         // pipeline is three deep, some margin
   localparam int DRAIN_LIMIT    = 20000;     // bound on waiting for outstanding status
   localparam int LONG_HOLD      = 400;       // receiver hold-off, fills the pipeline
   localparam int TIMEOUT_CYCLES = 3000000;

   // kinds of sample bursts
   typedef enum int {RG_WORKING, RG_QUIET, RG_HOT, RG_NOISE} regime_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [SAMPLE_W-1:0]   req_pressure_a = '0;
   logic [SAMPLE_W-1:0]   req_pressure_b = '0;
   logic [SAMPLE_W-1:0]   req_temperature = '0;
   logic [SAMPLE_W-1:0]   req_current_raw = '0;
   logic                  req_oil_temp_ok = 1'b1;

   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [STATE_W-1:0]    rsp_motor_state;
   logic [DUTY_W-1:0]     rsp_duty_permille;
   logic [PWM_W-1:0]      rsp_pwm_compare;
   logic [SAMPLE_W-1:0]   rsp_current_value;
   logic                  rsp_work_seen;
   logic                  rsp_over_current;
   logic                  rsp_under_load;
   logic                  rsp_over_temp;
   logic                  rsp_oil_over_temp;

   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // handshake between stimulus and receiver for the long hold-off
   bit hold_rsp    = 1'b0;
   bit rsp_holding = 1'b0;

   motor_status_tracker tracker;

   pump_motor_supervisor u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_pressure_a    (req_pressure_a),
      .req_pressure_b    (req_pressure_b),
      .req_temperature   (req_temperature),
      .req_current_raw   (req_current_raw),
      .req_oil_temp_ok   (req_oil_temp_ok),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_motor_state   (rsp_motor_state),
      .rsp_duty_permille (rsp_duty_permille),
      .rsp_pwm_compare   (rsp_pwm_compare),
      .rsp_current_value (rsp_current_value),
      .rsp_work_seen     (rsp_work_seen),
      .rsp_over_current  (rsp_over_current),
      .rsp_under_load    (rsp_under_load),
      .rsp_over_temp     (rsp_over_temp),
      .rsp_oil_over_temp (rsp_oil_over_temp),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // hard stop in case a handshake never completes
   initial begin
      #(TIMEOUT_CYCLES * 10);
      $display("CHECKS FAILED");
      $finish;
   end

   // ---------------------------------------------------------------- helpers

   function automatic adc_set_type adc(input logic [SAMPLE_W-1:0] pa,
                                       input logic [SAMPLE_W-1:0] pb,
                                       input logic [SAMPLE_W-1:0] t,
                                       input logic [SAMPLE_W-1:0] c,
                                       input logic ok);
      adc_set_type s;
      s.pressure_a  = pa;
      s.pressure_b  = pb;
      s.temperature = t;
      s.current_raw = c;
      s.oil_temp_ok = ok;
      return s;
   endfunction

   // gap length: mostly none or short, now and then a long one
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      else if (r < 88) return $urandom_range(1, 3);
      else if (r < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   // 12-bit register value with junk in the unused upper nibble
   function automatic logic [CSR_DATA_W-1:0] junk12(input int v);
      logic [CSR_DATA_W-1:0] r;
      r = CSR_DATA_W'(v);
      r[15:12] = 4'($urandom);
      return r;
   endfunction

   // random content shaped by the current thresholds
   function automatic adc_set_type make_samples(input regime_type rg);
      adc_set_type s;
      int tl, cool, hi;
      tl   = int'(tracker.temp_lvl);
      cool = (tl > 0) ? tl - 1 : 0;
      s.pressure_a  = SAMPLE_W'($urandom);
      s.pressure_b  = SAMPLE_W'($urandom);
      s.temperature = SAMPLE_W'($urandom);
      s.current_raw = SAMPLE_W'($urandom);
      s.oil_temp_ok = ($urandom_range(0, 9) != 0);
      case (rg)
         RG_WORKING: begin
            // one pressure channel at or above the start level
            if ($urandom_range(0, 1))
               s.pressure_a = SAMPLE_W'($urandom_range(int'(tracker.start_lvl), 4095));
            else
               s.pressure_b = SAMPLE_W'($urandom_range(int'(tracker.start_lvl), 4095));
            s.temperature = SAMPLE_W'($urandom_range(0, cool));
         end
         RG_QUIET: begin
            // low pressure, light load, normal temperature: lets the idle counter run
            s.pressure_a  = SAMPLE_W'($urandom_range(0, int'(tracker.stay_lvl) / 2));
            s.pressure_b  = SAMPLE_W'($urandom_range(0, int'(tracker.stay_lvl) / 2));
            hi = int'(tracker.offset_reg) + int'(tracker.under_lvl) / 2;
            if (hi > 4095) hi = 4095;
            s.current_raw = SAMPLE_W'($urandom_range(0, hi));
            s.temperature = SAMPLE_W'($urandom_range(0, cool));
         end
         RG_HOT: s.temperature = SAMPLE_W'($urandom_range(tl, 4095));
         default: ;
      endcase
      return s;
   endfunction

   // ---------------------------------------------------------------- drivers

   // offer one request, hold it until taken, then optionally go idle
   task automatic send_request(input adc_set_type s, input int gap);
      req_valid       <= 1'b1;
      req_pressure_a  <= s.pressure_a;
      req_pressure_b  <= s.pressure_b;
      req_temperature <= s.temperature;
      req_current_raw <= s.current_raw;
      req_oil_temp_ok <= s.oil_temp_ok;
      do @(posedge clock); while (req_stall);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop sending and wait until every expected status has come back or the drain limit runs out
   task automatic settle();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
         waited++;
      end while (tracker.pending() != 0 && waited < DRAIN_LIMIT);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_regs(input logic [CSR_DATA_W-1:0] offs, input logic [CSR_DATA_W-1:0] gain,
                               input logic [CSR_DATA_W-1:0] oc, input logic [CSR_DATA_W-1:0] ul,
                               input logic [CSR_DATA_W-1:0] stay,
                               input logic [CSR_DATA_W-1:0] start,
                               input logic [CSR_DATA_W-1:0] ot, input logic [CSR_DATA_W-1:0] tmo);
      write_reg(REG_CURRENT_OFFSET, offs);
      write_reg(REG_FILTER_GAIN, gain);
      write_reg(REG_OVERCURRENT_LEVEL, oc);
      write_reg(REG_UNDERLOAD_LEVEL, ul);
      write_reg(REG_STAY_WORK_LEVEL, stay);
      write_reg(REG_START_WORK_LEVEL, start);
      write_reg(REG_OVERTEMP_LEVEL, ot);
      write_reg(REG_IDLE_TIMEOUT, tmo);
   endtask

   // sensible random thresholds with a short idle timeout so sleep is reached
   task automatic random_settings();
      int stay;
      stay = $urandom_range(80, 1500);
      program_regs(junk12($urandom_range(0, 400)), CSR_DATA_W'($urandom_range(2000, 65535)),
                   junk12($urandom_range(0, 4095)), junk12($urandom_range(100, 1500)),
                   junk12(stay), junk12($urandom_range(stay, stay + 600)),
                   junk12($urandom_range(2500, 4095)), CSR_DATA_W'($urandom_range(0, 40)));
   endtask

   // bursts of working, quiet, hot and noise periods
   task automatic random_phase(input int count);
      int sent, len, pick, tmo;
      regime_type rg;
      bit steady;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 99);
         tmo  = int'(tracker.timeout_reg);
         if (pick < 40) begin
            rg  = RG_WORKING;
            len = $urandom_range(1, 30);
         end else if (pick < 72) begin
            // quiet bursts long enough to cross the idle timeout now and then
            rg  = RG_QUIET;
            len = (tmo <= 60) ? $urandom_range(1, tmo + 12) : $urandom_range(1, 40);
         end else if (pick < 77) begin
            rg  = RG_HOT;
            len = $urandom_range(1, 3);
         end else begin
            rg  = RG_NOISE;
            len = $urandom_range(1, 20);
         end
         steady = ($urandom_range(0, 6) == 0);   // back-to-back stretch
         repeat (len) begin
            if (sent < count) begin
               send_request(make_samples(rg), steady ? 0 : idle_len());
               sent++;
            end
         end
      end
   endtask

   // ---------------------------------------------------------------- receiver

   // random stall pattern, open stretches, and the long hold-off on request
   initial begin : rsp_side
      forever begin
         if (hold_rsp) begin
            hold_rsp    = 1'b0;
            rsp_holding = 1'b1;
            rsp_stall  <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_holding = 1'b0;
         end else if ($urandom_range(0, 24) == 0) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(40, 160)) @(posedge clock);
         end else if ($urandom_range(0, 99) < 35) begin
            rsp_stall <= 1'b1;
            repeat (idle_len() + 1) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   // register writes and requests update the prediction, status is checked in order
   always @(posedge clock) begin : watch
      motor_status_type got;
      if (!reset) begin
         if (csr_valid && csr_ready) tracker.write_reg(csr_index, csr_data);
         if (req_valid && !req_stall)
            tracker.take_samples(adc(req_pressure_a, req_pressure_b, req_temperature,
                                     req_current_raw, req_oil_temp_ok));
         if (rsp_valid && !rsp_stall) begin
            got.motor_state         = rsp_motor_state;
            got.duty_permille       = rsp_duty_permille;
            got.pwm_compare         = rsp_pwm_compare;
            got.current_value       = rsp_current_value;
            got.flags.work_seen     = rsp_work_seen;
            got.flags.over_current  = rsp_over_current;
            got.flags.under_load    = rsp_under_load;
            got.flags.over_temp     = rsp_over_temp;
            got.flags.oil_over_temp = rsp_oil_over_temp;
            tracker.compare_status(got);
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   initial begin : stimulus
      tracker = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed periods on the reset thresholds
      send_request(adc(12'd0, 12'd0, 12'd0, 12'd0, 1'b1), 0);
      send_request(adc(12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b0), 0);  // over temp
      send_request(adc(12'd0, 12'd0, 12'd0, 12'd0, 1'b1), idle_len());      // error back to work
      repeat (4) send_request(adc(12'd4095, 12'd0, 12'd3007, 12'd4095, 1'b1), 0);  // load rises
      send_request(adc(12'd0, 12'd4095, 12'd3008, 12'd4095, 1'b1), 1);     // temp at level
      send_request(adc(12'd0, 12'd4095, 12'd3007, 12'd0, 1'b0), 0);        // just below, oil hot
      repeat (4) send_request(adc(12'd0, 12'd0, 12'd100, 12'd0, 1'b1), idle_len());
      send_request(adc(12'd300, 12'd0, 12'd0, 12'd2048, 1'b1), 0);
      repeat (2) send_request(adc(12'd4095, 12'd4095, 12'd2000, 12'd2048, 1'b1), 0);
      send_request(adc(12'd0, 12'd0, 12'd4095, 12'd0, 1'b1), 2);
      send_request(adc(12'd0, 12'd0, 12'd0, 12'd0, 1'b0), 0);
      settle();

      // typical thresholds, short idle timeout
      program_regs(junk12(100), 16'd25736, junk12(2000), junk12(400), junk12(200), junk12(300),
                   junk12(3008), 16'd20);
      random_phase(200);

      // long receiver hold-off while requests keep coming: input must stall
      hold_rsp = 1'b1;
      while (!rsp_holding) @(posedge clock);
      repeat (80) send_request(make_samples(regime_type'($urandom_range(0, 3))), 0);
      // sender pause until the pipeline is empty
      settle();
      random_phase(60);
      settle();

      // everything at zero: filters frozen, every threshold flag set, always over temp
      program_regs(junk12(0), 16'd0, junk12(0), junk12(0), junk12(0), junk12(0), junk12(0),
                   16'd0);
      random_phase(50);
      settle();

      // everything at maximum
      program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      random_phase(120);
      settle();

      repeat (3) begin
         random_settings();
         random_phase(120);
         settle();
      end

      // quiet run into sleep, then work, over temperature back through error, and noise
      program_regs(junk12(0), 16'hFFFF, junk12(2048), junk12(4095), junk12(2000), junk12(2000),
                   junk12(4095), 16'd2);
      repeat (40) send_request(make_samples(RG_QUIET), idle_len());
      repeat (10) send_request(make_samples(RG_WORKING), idle_len());
      repeat (2) send_request(make_samples(RG_HOT), idle_len());
      repeat (10) send_request(make_samples(RG_NOISE), idle_len());

      settle();
      tracker.count_leftover();
      if (tracker.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
